### hw/rtl/pfs_pkg.sv
// pfs_pkg: shared types and constants of the priority flow scheduler
// queue depth, entry layout, cell control struct
// no dependencies
package pfs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // first member is the most significant; the key is everything above the id
    typedef struct packed {
        logic [7:0]  prio_value;
        logic [15:0] arrival_tenths;
        logic [15:0] xmit_tenths;
        logic [7:0]  input_order;
        logic [7:0]  flow_id;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

    function automatic logic [47:0] entry_key(input t_entry e);
        entry_key = {e.prio_value, e.arrival_tenths, e.xmit_tenths, e.input_order};
    endfunction

endpackage

### hw/rtl/pfs_cell.sv
// pfs_cell: one slot of the sorted waiting queue
// compares its key with the arriving flow and shifts left or right as told
// depends on pfs_pkg
module pfs_cell
    import pfs_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  t_entry     i_new_entry,
    input  t_entry     i_left_entry,
    input  logic       i_left_stays,
    input  t_entry     i_right_entry,
    output t_entry     o_entry,
    output logic       o_stays
);

    t_entry r_entry;
    t_entry n_entry;

    // entry keeps its slot when strictly ahead of the new flow
    assign o_stays = i_occupied && (entry_key(r_entry) < entry_key(i_new_entry));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (o_stays) begin
                n_entry = r_entry;
            end else if (i_left_stays) begin
                // first slot behind the ones that stay takes the new flow
                n_entry = i_new_entry;
            end else begin
                // head sees the new flow as its left neighbor
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hw/rtl/priority_flow_scheduler.sv
// priority_flow_scheduler: non-preemptive priority scheduler for one shared link
// top level with link state, result register and a row of pfs_cell slots
// depends on pfs_pkg and pfs_cell
//
// One flow holds the link at a time. An arrive transfer (tuser = 0) starts the
// flow at once when the link is idle; otherwise the flow is placed in a sorted
// waiting queue of QUEUE_DEPTH slots and the result names the flow it waits on.
// Order is ascending by priority value, then arrival time, then transmission
// time, then input order; a new flow goes ahead of any entry with an equal key.
// A finish transfer (tuser = 1) retires the transmitting flow and starts the
// head of the queue if there is one. An arrival into a full queue or a finish
// on an idle link is dropped and flagged, leaving the state as it was. Every
// input transfer gives exactly one result transfer. The queue is a chain of
// identical cells: on an insert each cell compares its key with the new flow
// in parallel and either holds, takes the new flow or takes its left neighbor;
// when a finish pops the head every cell takes its right neighbor. This
// compare-and-shift lets one item be accepted every clock cycle, with the
// result in the output register in the next cycle; the input stalls only
// while that register holds a result that is not taken.
module priority_flow_scheduler
    import pfs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // flow_id[7:0], prio_value[15:8], arrival_tenths[31:16],
    // xmit_tenths[47:32], input_order[55:48]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // func[0]
    input  logic                   i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // start_valid[0], start_flow_id[8:1], wait_valid[9],
    // wait_on_flow_id[17:10], dropped[18], waiting_count[23:19]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // link state
    logic             r_busy;
    logic             n_busy;
    logic [7:0]       r_cur_flow;
    logic [7:0]       n_cur_flow;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic       accept;
    t_entry     new_entry;
    t_cell_ctrl cell_ctrl;

    // result fields of the item being accepted
    logic       res_start;
    logic [7:0] res_start_id;
    logic       res_wait;
    logic [7:0] res_wait_on;
    logic       res_dropped;

    t_entry                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_stays;
    logic [QUEUE_DEPTH-1:0] cell_occ;

    // output register frees up when its result is taken
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign new_entry.flow_id        = i_s_tdata[7:0];
    assign new_entry.prio_value     = i_s_tdata[15:8];
    assign new_entry.arrival_tenths = i_s_tdata[31:16];
    assign new_entry.xmit_tenths    = i_s_tdata[47:32];
    assign new_entry.input_order    = i_s_tdata[55:48];

    // decide what the item does to link, queue and result
    always_comb begin
        n_busy           = r_busy;
        n_cur_flow       = r_cur_flow;
        n_count          = r_count;
        cell_ctrl.insert = 1'b0;
        cell_ctrl.pop    = 1'b0;
        res_start        = 1'b0;
        res_start_id     = 8'd0;
        res_wait         = 1'b0;
        res_wait_on      = 8'd0;
        res_dropped      = 1'b0;
        if (i_s_tuser == FUNC_ARRIVE) begin
            if (!r_busy) begin
                // idle link: start right away
                n_busy       = 1'b1;
                n_cur_flow   = new_entry.flow_id;
                res_start    = 1'b1;
                res_start_id = new_entry.flow_id;
            end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                res_dropped = 1'b1;
            end else begin
                cell_ctrl.insert = 1'b1;
                n_count          = r_count + CNT_W'(1);
                res_wait         = 1'b1;
                res_wait_on      = r_cur_flow;
            end
        end else begin
            if (!r_busy) begin
                res_dropped = 1'b1;
            end else if (r_count == '0) begin
                n_busy = 1'b0;
            end else begin
                // head of queue takes the link
                cell_ctrl.pop = 1'b1;
                n_cur_flow    = cell_entry[0].flow_id;
                n_count       = r_count - CNT_W'(1);
                res_start     = 1'b1;
                res_start_id  = cell_entry[0].flow_id;
            end
        end
        if (!accept) begin
            cell_ctrl.insert = 1'b0;
            cell_ctrl.pop    = 1'b0;
        end
    end

    // row of queue cells, head at index 0
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_entry left_entry;
            t_entry right_entry;
            logic   left_stays;

            assign cell_occ[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign left_entry = new_entry;
                assign left_stays = 1'b0;
            end else begin : g_body
                assign left_entry = cell_entry[gi-1];
                assign left_stays = cell_stays[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign right_entry = cell_entry[gi];
            end else begin : g_mid
                assign right_entry = cell_entry[gi+1];
            end

            pfs_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (cell_ctrl),
                .i_occupied    (cell_occ[gi]),
                .i_new_entry   (new_entry),
                .i_left_entry  (left_entry),
                .i_left_stays  (left_stays),
                .i_right_entry (right_entry),
                .o_entry       (cell_entry[gi]),
                .o_stays       (cell_stays[gi])
            );
        end
    endgenerate

    // link state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur_flow  <= 8'd0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy      <= n_busy;
                r_cur_flow  <= n_cur_flow;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {5'(n_count), res_dropped, res_wait_on, res_wait,
                           res_start_id, res_start};
        end
    end

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("waiting count above queue depth");

    // nobody waits while the link is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_count == '0))
        else $error("queue not empty on idle link");

    // a queued arrival grows the queue by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cell_ctrl.insert) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow queue");

    // a dropped item neither starts nor queues a flow
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[18]) |-> (!o_m_tdata[0] && !o_m_tdata[9]))
        else $error("dropped result also starts or queues");

    // a finish that starts a flow hands it the old queue head
    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cell_ctrl.pop) |=> (r_cur_flow == $past(cell_entry[0].flow_id)))
        else $error("started flow is not the queue head");

endmodule
